// ----- hw/rtl/cmdsplit_pkg.sv -----
package cmdsplit_pkg;

  // Byte classes assigned by the front end
  typedef enum logic [2:0] {
    CLS_OTHER  = 3'd0,
    CLS_WS     = 3'd1,
    CLS_BS     = 3'd2,
    CLS_QUOTE  = 3'd3,
    CLS_DOLLAR = 3'd4,
    CLS_PCT    = 3'd5,
    CLS_STAR   = 3'd6,
    CLS_ONE    = 3'd7
  } cls_e;

  // Result token kinds
  typedef enum logic [2:0] {
    KIND_BYTE      = 3'd0,
    KIND_END_ARG   = 3'd1,
    KIND_PROG_BS   = 3'd2,
    KIND_PROG_VERB = 3'd3,
    KIND_QUERY     = 3'd4,
    KIND_END_LIST  = 3'd5
  } kind_e;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_BS     = 8'h5C;

  // Queue and lookahead sizes
  localparam int MidDepth = 2;
  localparam int MidAw    = 1;
  localparam int OutDepth = 4;
  localparam int OutAw    = 2;
  localparam int BufDepth = 4;
  localparam int BufAw    = 2;

  typedef struct packed {
    logic [7:0] ch;
    cls_e       cls;
  } tchar_t;

  typedef struct packed {
    tchar_t c;
    logic   eos;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } item_chan_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] bval;
    logic       last;
  } res_t;

  typedef struct packed {
    logic push;
    res_t res;
  } res_chan_t;

  function automatic cls_e classify(logic [7:0] c);
    cls_e r;
    r = CLS_OTHER;
    if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) r = CLS_WS;
    else if (c == CH_BS)     r = CLS_BS;
    else if (c == CH_QUOTE)  r = CLS_QUOTE;
    else if (c == CH_DOLLAR) r = CLS_DOLLAR;
    else if (c == CH_PCT)    r = CLS_PCT;
    else if (c == CH_STAR)   r = CLS_STAR;
    else if (c == CH_ONE)    r = CLS_ONE;
    return r;
  endfunction

endpackage

// ----- hw/rtl/cmdsplit_front.sv -----
module cmdsplit_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  logic [7:0]               char_in_i,
  input  logic                     end_of_string_i,
  output logic                     full_o,
  output cmdsplit_pkg::item_chan_t mid_o,
  input  logic                     mid_pop_i
);

  cmdsplit_pkg::item_t                   mem_q [cmdsplit_pkg::MidDepth];
  logic [cmdsplit_pkg::MidAw-1:0]        wr_q, rd_q;
  logic [cmdsplit_pkg::MidAw:0]          cnt_q, cnt_d;
  logic                                  wr_en, rd_en;
  cmdsplit_pkg::item_t                   new_item;

  // Classify the incoming byte
  always_comb begin
    new_item.c.ch  = char_in_i;
    new_item.c.cls = cmdsplit_pkg::classify(char_in_i);
    new_item.eos   = end_of_string_i;
  end

  assign full_o      = (cnt_q == (cmdsplit_pkg::MidAw+1)'(cmdsplit_pkg::MidDepth));
  assign wr_en       = push_i && !full_o;
  assign mid_o.valid = (cnt_q != '0);
  assign mid_o.item  = mem_q[rd_q];
  assign rd_en       = mid_pop_i && mid_o.valid;

  always_comb begin
    cnt_d = cnt_q;
    case ({wr_en, rd_en})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  // Queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_en) wr_q <= wr_q + 1'b1;
      if (rd_en) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_q] <= new_item;
  end

endmodule

// ----- hw/rtl/cmdsplit_outq.sv -----
module cmdsplit_outq (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cmdsplit_pkg::res_chan_t in_i,
  output logic                    full_o,
  output logic                    empty_o,
  input  logic                    pop_i,
  output cmdsplit_pkg::res_t      res_o
);

  cmdsplit_pkg::res_t             mem_q [cmdsplit_pkg::OutDepth];
  logic [cmdsplit_pkg::OutAw-1:0] wr_q, rd_q;
  logic [cmdsplit_pkg::OutAw:0]   cnt_q, cnt_d;
  logic                           wr_en, rd_en;

  assign full_o  = (cnt_q == (cmdsplit_pkg::OutAw+1)'(cmdsplit_pkg::OutDepth));
  assign empty_o = (cnt_q == '0);
  assign wr_en   = in_i.push && !full_o;
  assign rd_en   = pop_i && !empty_o;
  assign res_o   = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    case ({wr_en, rd_en})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  // Queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_en) wr_q <= wr_q + 1'b1;
      if (rd_en) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_q] <= in_i.res;
  end

endmodule

// ----- hw/rtl/cmdsplit_back.sv -----
module cmdsplit_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cmdsplit_pkg::item_chan_t mid_i,
  output logic                     mid_pop_o,
  output cmdsplit_pkg::res_chan_t  out_o,
  input  logic                     out_full_i
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_RUN    = 4'b0010,
    ST_FINISH = 4'b0100,
    ST_CLOSE  = 4'b1000
  } state_e;

  state_e                       state_q, state_d;
  cmdsplit_pkg::tchar_t         buf_q [cmdsplit_pkg::BufDepth];
  cmdsplit_pkg::tchar_t         buf_d [cmdsplit_pkg::BufDepth];
  logic [cmdsplit_pkg::BufAw:0] cnt_q, cnt_d;
  logic                         eos_q, eos_d;
  logic                         in_arg_q, in_arg_d;
  logic                         in_quo_q, in_quo_d;
  logic                         held_q, held_d;
  logic                         qpend_q, qpend_d;
  logic                         dup_q, dup_d;
  logic                         prog_q, prog_d;
  logic                         query_q, query_d;
  cmdsplit_pkg::kind_e          hold_kind_q, hold_kind_d;
  logic [7:0]                   hold_byte_q, hold_byte_d;
  logic                         hold_vld_q, hold_vld_d;

  logic                         adv;
  logic                         emit;
  cmdsplit_pkg::kind_e          e_kind;
  logic [7:0]                   e_byte;
  logic [2:0]                   sh;
  logic                         flush;
  logic                         load;
  logic                         start_arg;
  cmdsplit_pkg::cls_e           cl0, cl1, cl2, cl3;
  logic [7:0]                   ch0;
  logic                         need2, need3, need4;
  cmdsplit_pkg::kind_e          pk1;

  // Stall whenever a transfer to the result queue would be refused
  assign adv = !(hold_vld_q && out_full_i);

  // Classes at the four lookahead slots; missing bytes read as plain
  assign ch0 = buf_q[0].ch;
  assign cl0 = (cnt_q > 3'd0) ? buf_q[0].cls : cmdsplit_pkg::CLS_OTHER;
  assign cl1 = (cnt_q > 3'd1) ? buf_q[1].cls : cmdsplit_pkg::CLS_OTHER;
  assign cl2 = (cnt_q > 3'd2) ? buf_q[2].cls : cmdsplit_pkg::CLS_OTHER;
  assign cl3 = (cnt_q > 3'd3) ? buf_q[3].cls : cmdsplit_pkg::CLS_OTHER;

  // More bytes are needed before a marker can be decided
  assign need2 = (cnt_q < 3'd2) && !eos_q;
  assign need3 = (cnt_q < 3'd3) && !eos_q;
  assign need4 = (cnt_q < 3'd4) && !eos_q;
  assign pk1   = (cl1 == cmdsplit_pkg::CLS_PCT) ? cmdsplit_pkg::KIND_PROG_BS
                                                : cmdsplit_pkg::KIND_PROG_VERB;

  // Parser sequencer: one action and at most one result per cycle while not stalled
  always_comb begin
    state_d   = state_q;
    in_arg_d  = in_arg_q;
    in_quo_d  = in_quo_q;
    held_d    = held_q;
    qpend_d   = qpend_q;
    dup_d     = dup_q;
    prog_d    = prog_q;
    query_d   = query_q;
    emit      = 1'b0;
    e_kind    = cmdsplit_pkg::KIND_BYTE;
    e_byte    = 8'h00;
    sh        = 3'd0;
    flush     = 1'b0;
    load      = 1'b0;
    start_arg = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (mid_i.valid) begin
          load    = 1'b1;
          state_d = ST_RUN;
        end
      end

      ST_RUN: begin
        if (cnt_q == '0) begin
          // buffer drained
          if (eos_q) begin
            state_d = ST_FINISH;
          end else begin
            flush = 1'b1;
            load  = mid_i.valid;
            state_d = mid_i.valid ? ST_RUN : ST_IDLE;
          end
        end else if (in_arg_q) begin
          if (dup_q) begin
            // second half of a backslash pair
            emit   = 1'b1;
            e_byte = cmdsplit_pkg::CH_BS;
            dup_d  = 1'b0;
            sh     = 3'd1;
          end else if (held_q) begin
            held_d = 1'b0;
            emit   = 1'b1;
            if (cl0 == cmdsplit_pkg::CLS_BS) begin
              e_byte = cmdsplit_pkg::CH_BS;
              dup_d  = 1'b1;
            end else if (cl0 == cmdsplit_pkg::CLS_QUOTE) begin
              e_byte = cmdsplit_pkg::CH_QUOTE;
              sh     = 3'd1;
            end else begin
              // release the held backslash, replay this byte
              e_byte = cmdsplit_pkg::CH_BS;
            end
          end else if (qpend_q) begin
            qpend_d = 1'b0;
            if (cl0 == cmdsplit_pkg::CLS_QUOTE) begin
              emit   = 1'b1;
              e_byte = cmdsplit_pkg::CH_QUOTE;
              sh     = 3'd1;
            end else begin
              in_quo_d = 1'b0;
            end
          end else begin
            sh = 3'd1;
            if (cl0 == cmdsplit_pkg::CLS_WS && !in_quo_q) begin
              emit     = 1'b1;
              e_kind   = cmdsplit_pkg::KIND_END_ARG;
              in_arg_d = 1'b0;
              in_quo_d = 1'b0;
            end else if (cl0 == cmdsplit_pkg::CLS_BS) begin
              held_d = 1'b1;
            end else if (cl0 == cmdsplit_pkg::CLS_QUOTE) begin
              if (in_quo_q) qpend_d = 1'b1;
              else          in_quo_d = 1'b1;
            end else begin
              emit   = 1'b1;
              e_byte = ch0;
            end
          end
        end else begin
          // between arguments: look for markers
          case (cl0)
            cmdsplit_pkg::CLS_WS: sh = 3'd1;
            cmdsplit_pkg::CLS_DOLLAR, cmdsplit_pkg::CLS_PCT: begin
              if (need2) begin
                flush   = 1'b1;
                load    = mid_i.valid;
                state_d = mid_i.valid ? ST_RUN : ST_IDLE;
              end else if (cl1 == cmdsplit_pkg::CLS_STAR) begin
                emit    = 1'b1;
                e_kind  = cmdsplit_pkg::KIND_QUERY;
                query_d = 1'b1;
                sh      = 3'd2;
              end else if (cl1 == cmdsplit_pkg::CLS_ONE) begin
                emit   = 1'b1;
                e_kind = (cl0 == cmdsplit_pkg::CLS_PCT) ? cmdsplit_pkg::KIND_PROG_BS
                                                        : cmdsplit_pkg::KIND_PROG_VERB;
                prog_d = 1'b1;
                sh     = 3'd2;
              end else begin
                start_arg = 1'b1;
              end
            end
            cmdsplit_pkg::CLS_QUOTE: begin
              if (need2 || ((cl1 == cmdsplit_pkg::CLS_DOLLAR ||
                             cl1 == cmdsplit_pkg::CLS_PCT) &&
                            (need3 || (cl2 == cmdsplit_pkg::CLS_ONE && need4)))) begin
                flush   = 1'b1;
                load    = mid_i.valid;
                state_d = mid_i.valid ? ST_RUN : ST_IDLE;
              end else if ((cl1 == cmdsplit_pkg::CLS_DOLLAR ||
                             cl1 == cmdsplit_pkg::CLS_PCT) &&
                            cl2 == cmdsplit_pkg::CLS_ONE &&
                            cl3 == cmdsplit_pkg::CLS_QUOTE) begin
                emit   = 1'b1;
                e_kind = pk1;
                prog_d = 1'b1;
                sh     = 3'd4;
              end else begin
                start_arg = 1'b1;
              end
            end
            default: start_arg = 1'b1;
          endcase
        end
      end

      ST_FINISH: begin
        // trailing tokens, one per cycle while not stalled
        emit = 1'b1;
        if (in_arg_q && held_q) begin
          e_byte = cmdsplit_pkg::CH_BS;
          held_d = 1'b0;
        end else if (in_arg_q) begin
          e_kind   = cmdsplit_pkg::KIND_END_ARG;
          in_arg_d = 1'b0;
        end else if (!prog_q) begin
          e_kind = cmdsplit_pkg::KIND_PROG_VERB;
          prog_d = 1'b1;
        end else if (!query_q) begin
          e_kind  = cmdsplit_pkg::KIND_QUERY;
          query_d = 1'b1;
        end else begin
          e_kind   = cmdsplit_pkg::KIND_END_LIST;
          in_quo_d = 1'b0;
          qpend_d  = 1'b0;
          held_d   = 1'b0;
          dup_d    = 1'b0;
          prog_d   = 1'b0;
          query_d  = 1'b0;
          state_d  = ST_CLOSE;
        end
      end

      ST_CLOSE: begin
        flush   = 1'b1;
        load    = mid_i.valid;
        state_d = mid_i.valid ? ST_RUN : ST_IDLE;
      end

      default: state_d = ST_IDLE;
    endcase

    if (start_arg) begin
      in_arg_d = 1'b1;
      in_quo_d = 1'b0;
      held_d   = 1'b0;
      qpend_d  = 1'b0;
    end
  end

  // Lookahead buffer: consume from the front, append the loaded byte
  always_comb begin
    for (int k = 0; k < cmdsplit_pkg::BufDepth; k++) buf_d[k] = buf_q[k];
    cnt_d = cnt_q - sh;
    eos_d = eos_q;
    case (sh)
      3'd1: begin
        buf_d[0] = buf_q[1];
        buf_d[1] = buf_q[2];
        buf_d[2] = buf_q[3];
      end
      3'd2: begin
        buf_d[0] = buf_q[2];
        buf_d[1] = buf_q[3];
      end
      default: ;
    endcase
    if (load) begin
      eos_d = mid_i.item.eos;
      if (!mid_i.item.eos) begin
        buf_d[cnt_q[cmdsplit_pkg::BufAw-1:0]] = mid_i.item.c;
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  // The newest result waits in a hold register until its successor shows
  // whether it closes the run
  always_comb begin
    hold_kind_d = hold_kind_q;
    hold_byte_d = hold_byte_q;
    hold_vld_d  = hold_vld_q;
    out_o.push     = adv && hold_vld_q && (emit || flush);
    out_o.res.kind = hold_kind_q;
    out_o.res.bval = hold_byte_q;
    out_o.res.last = flush;
    if (emit) begin
      hold_kind_d = e_kind;
      hold_byte_d = (e_kind == cmdsplit_pkg::KIND_BYTE) ? e_byte : 8'h00;
      hold_vld_d  = 1'b1;
    end else if (flush) begin
      hold_vld_d = 1'b0;
    end
  end

  assign mid_pop_o = adv && load;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      eos_q      <= 1'b0;
      in_arg_q   <= 1'b0;
      in_quo_q   <= 1'b0;
      held_q     <= 1'b0;
      qpend_q    <= 1'b0;
      dup_q      <= 1'b0;
      prog_q     <= 1'b0;
      query_q    <= 1'b0;
      hold_vld_q <= 1'b0;
    end else if (adv) begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      eos_q      <= eos_d;
      in_arg_q   <= in_arg_d;
      in_quo_q   <= in_quo_d;
      held_q     <= held_d;
      qpend_q    <= qpend_d;
      dup_q      <= dup_d;
      prog_q     <= prog_d;
      query_q    <= query_d;
      hold_vld_q <= hold_vld_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < cmdsplit_pkg::BufDepth; k++) buf_q[k] <= buf_d[k];
      hold_kind_q <= hold_kind_d;
      hold_byte_q <= hold_byte_d;
    end
  end

  // Lookahead never exceeds three bytes outside of parsing
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_RUN |-> cnt_q <= 3'd3)
    else $error("lookahead overflow");

  // A held backslash and a pending quote exclude each other
  a_held_qpend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(held_q && qpend_q))
    else $error("held backslash with pending quote");

  // Backslash pair second half only inside an argument with a byte present
  a_dup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dup_q |-> (in_arg_q && !held_q && cnt_q != '0 && state_q == ST_RUN))
    else $error("stray backslash pair state");

  // Nothing stays in the hold register once idle
  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !hold_vld_q)
    else $error("result left in hold register");

  // End of list leaves the parser in its reset state with the token held
  a_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLOSE |-> (!in_arg_q && !prog_q && !query_q && hold_vld_q &&
                             hold_kind_q == cmdsplit_pkg::KIND_END_LIST))
    else $error("template end did not clear state");

endmodule

// ----- hw/rtl/command_line_arg_splitter_unit.sv -----
// Channel   Direction  Handshake         Payload
// input     in         push / full       char_in_i, end_of_string_i
// result    out        empty / pop       kind_o, byte_out_o, last_of_run_o
//
// A byte inside an argument takes a parse step and then a step that closes
// the run and loads the next byte. Each further result, replayed lookahead
// byte or argument start adds a step; the sequencer in the back end emits at
// most one result per cycle. An end-of-string transfer takes a step that
// finds the buffer drained, up to five trailing tokens and a step that closes
// the run, plus a step per replayed lookahead result.
// Reset (rst_ni low, asynchronous) empties both queues and the parser state.
// Input and result sides stall independently through the queues between them.
module command_line_arg_splitter_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] char_in_i,
  input  logic       end_of_string_i,
  output logic       empty,
  input  logic       pop,
  output logic [2:0] kind_o,
  output logic [7:0] byte_out_o,
  output logic       last_of_run_o
);

  cmdsplit_pkg::item_chan_t mid;
  logic                     mid_pop;
  cmdsplit_pkg::res_chan_t  res_chan;
  logic                     out_full;
  cmdsplit_pkg::res_t       res;

  // Front end: accept and classify bytes
  cmdsplit_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .char_in_i       (char_in_i),
    .end_of_string_i (end_of_string_i),
    .full_o          (full),
    .mid_o           (mid),
    .mid_pop_i       (mid_pop)
  );

  // Back end: parse and produce tokens
  cmdsplit_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .mid_i      (mid),
    .mid_pop_o  (mid_pop),
    .out_o      (res_chan),
    .out_full_i (out_full)
  );

  // Result queue
  cmdsplit_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (res_chan),
    .full_o  (out_full),
    .empty_o (empty),
    .pop_i   (pop),
    .res_o   (res)
  );

  assign kind_o        = res.kind;
  assign byte_out_o    = res.bval;
  assign last_of_run_o = res.last;

endmodule
